>>> hw/rtl/lltr_pkg.sv
// Package for the log level tagger ring: character codes, parser phases and
// the burst record passed from the parser to the output stage. No dependencies.
package lltr_pkg;

  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NL   = 8'h0A;

  localparam int unsigned MaxBurst = 6;
  localparam int unsigned CntW     = 3;

  localparam logic [1:0] PH_LT  = 2'd0;
  localparam logic [1:0] PH_DIG = 2'd1;
  localparam logic [1:0] PH_GT  = 2'd2;

  localparam logic [2:0] DEFAULT_LEVEL_RST = 3'd4;

  typedef struct packed {
    logic [MaxBurst-1:0][7:0] bytes;
    logic [CntW-1:0]          cnt;
    logic [2:0]               level;
  } burst_t;

  function automatic logic [7:0] digit_ch(input logic [2:0] lvl);
    digit_ch = {5'b00110, lvl};
  endfunction

endpackage

>>> hw/rtl/lltr_parser.sv
// Line prefix parser: tracks the line state and turns one character into a
// burst of zero to six bytes. Depends on lltr_pkg.
module lltr_parser import lltr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i,
  input  logic       accept_i,
  input  logic [7:0] char_i,
  output burst_t     burst_o
);

  logic       known_q, known_d;
  logic [2:0] level_q, level_d;
  logic [1:0] phase_q, phase_d;
  logic [2:0] held_q, held_d;
  logic [2:0] dflt_q;
  logic [7:0] dflt_ch;

  assign dflt_ch = digit_ch(dflt_q);

  always_comb begin
    burst_o = '0;
    known_d = known_q;
    level_d = level_q;
    phase_d = phase_q;
    held_d  = held_q;
    if (known_q) begin
      burst_o.bytes[0] = char_i;
      burst_o.cnt      = CntW'(1);
      burst_o.level    = level_q;
    end else begin
      case (phase_q)
        PH_DIG: begin
          if (char_i inside {[CH_ZERO:CH_SEVEN]}) begin
            held_d  = char_i[2:0];
            phase_d = PH_GT;
          end else begin
            burst_o.bytes[0] = CH_LT;
            burst_o.bytes[1] = dflt_ch;
            burst_o.bytes[2] = CH_GT;
            burst_o.bytes[3] = CH_LT;
            burst_o.bytes[4] = char_i;
            burst_o.cnt      = CntW'(5);
            burst_o.level    = dflt_q;
            level_d = dflt_q;
            known_d = 1'b1;
            phase_d = PH_LT;
          end
        end
        PH_GT: begin
          known_d = 1'b1;
          phase_d = PH_LT;
          if (char_i == CH_GT) begin
            burst_o.bytes[0] = CH_LT;
            burst_o.bytes[1] = digit_ch(held_q);
            burst_o.bytes[2] = CH_GT;
            burst_o.cnt      = CntW'(3);
            burst_o.level    = held_q;
            level_d = held_q;
          end else begin
            burst_o.bytes[0] = CH_LT;
            burst_o.bytes[1] = dflt_ch;
            burst_o.bytes[2] = CH_GT;
            burst_o.bytes[3] = CH_LT;
            burst_o.bytes[4] = digit_ch(held_q);
            burst_o.bytes[5] = char_i;
            burst_o.cnt      = CntW'(6);
            burst_o.level    = dflt_q;
            level_d = dflt_q;
          end
        end
        default: begin
          if (char_i == CH_LT) begin
            phase_d = PH_DIG;
          end else begin
            burst_o.bytes[0] = CH_LT;
            burst_o.bytes[1] = dflt_ch;
            burst_o.bytes[2] = CH_GT;
            burst_o.bytes[3] = char_i;
            burst_o.cnt      = CntW'(4);
            burst_o.level    = dflt_q;
            level_d = dflt_q;
            known_d = 1'b1;
            phase_d = PH_LT;
          end
        end
      endcase
    end
    // newline ends the line whatever came before
    if (char_i == CH_NL) begin
      known_d = 1'b0;
      phase_d = PH_LT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      known_q <= 1'b0;
      level_q <= '0;
      phase_q <= PH_LT;
      held_q  <= '0;
    end else if (accept_i) begin
      known_q <= known_d;
      level_q <= level_d;
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_q <= DEFAULT_LEVEL_RST;
    end else if (cfg_we_i) begin
      dflt_q <= cfg_wdata_i;
    end
  end

endmodule

>>> hw/rtl/lltr_burst.sv
// Result register: holds the current burst and shifts out one byte per beat.
// Depends on lltr_pkg.
module lltr_burst import lltr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  burst_t     burst_i,
  input  logic       out_ready_i,
  output logic       ready_o,
  output logic       out_valid_o,
  output logic       fire_o,
  output logic [7:0] byte_o,
  output logic [2:0] level_o,
  output logic       last_o
);

  burst_t burst_q;

  assign out_valid_o = burst_q.cnt != '0;
  assign last_o      = burst_q.cnt == CntW'(1);
  assign fire_o      = out_valid_o && out_ready_i;
  assign ready_o     = !out_valid_o || (out_ready_i && last_o);
  assign byte_o      = burst_q.bytes[0];
  assign level_o     = burst_q.level;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_q <= '0;
    end else if (load_i) begin
      burst_q <= burst_i;
    end else if (fire_o) begin
      burst_q.bytes <= burst_q.bytes >> 8;
      burst_q.cnt   <= burst_q.cnt - CntW'(1);
    end
  end

endmodule

>>> hw/rtl/lltr_ring.sv
// Circular log store with write pointer and running byte count.
// Standalone; no package needed.
module lltr_ring #(
  parameter int unsigned LOG_DEPTH = 16384
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_i,
  input  logic [7:0]  wdata_i,
  output logic [13:0] index_o,
  output logic [31:0] total_o
);

  localparam int unsigned PtrW = $clog2(LOG_DEPTH);

  logic [7:0]      log_mem_q [LOG_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [31:0]     total_q;
  logic [31:0]     ptr_ext;

  assign ptr_ext  = 32'(wr_ptr_q);
  assign index_o  = ptr_ext[13:0];
  assign total_o  = total_q + 32'd1;
  assign wr_ptr_d = (wr_ptr_q == PtrW'(LOG_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      log_mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      total_q  <= '0;
    end else if (wr_i) begin
      wr_ptr_q <= wr_ptr_d;
      total_q  <= total_q + 32'd1;
    end
  end

endmodule

>>> hw/rtl/log_level_tagger_ring_top.sv
// Log level tagger ring top: parser, result register and circular store.
// The first beat of an item is presented in the cycle after it is accepted.
// Throughput: one byte per cycle while out_ready_i is high; an item yields 0 to 6
// beats and the next item is taken in the cycle of the previous item's last beat.
// Reset (async, active low) clears parser, pointers and counts; the store
// itself is not cleared. Depends on lltr_pkg, lltr_parser, lltr_burst, lltr_ring.
module log_level_tagger_ring_top import lltr_pkg::*; #(
  parameter int unsigned LOG_DEPTH = 16384
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [13:0] ring_index_o,
  output logic [7:0]  byte_written_o,
  output logic [2:0]  line_level_o,
  output logic [31:0] total_logged_o,
  output logic        last_o
);

  logic   accept;
  logic   fire;
  burst_t burst;

  assign accept = in_valid_i && in_ready_o;

  lltr_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .char_i     (char_in_i),
    .burst_o    (burst)
  );

  lltr_burst u_burst (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .burst_i    (burst),
    .out_ready_i(out_ready_i),
    .ready_o    (in_ready_o),
    .out_valid_o(out_valid_o),
    .fire_o     (fire),
    .byte_o     (byte_written_o),
    .level_o    (line_level_o),
    .last_o     (last_o)
  );

  lltr_ring #(
    .LOG_DEPTH(LOG_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (fire),
    .wdata_i(byte_written_o),
    .index_o(ring_index_o),
    .total_o(total_logged_o)
  );

  a_take_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && out_valid_o |-> out_ready_i && last_o)
    else $error("input taken while burst still draining");

  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !last_o |=> out_valid_o)
    else $error("burst dropped before last beat");

  a_count_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> total_logged_o == $past(total_logged_o) + 32'd1)
    else $error("byte count did not advance");

  a_count_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(total_logged_o) && $stable(ring_index_o))
    else $error("store pointer moved without a beat");

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Testbench for log_level_tagger_ring_top: drives a character stream, predicts every
// store write (prefix tagging, circular index, running count) and checks each beat.
// Depends on lltr_pkg and the block's RTL only.
module tb;
  import lltr_pkg::*;

  localparam int LogDepth = 16384;

  typedef struct packed {
    logic [13:0] idx;
    logic [7:0]  data;
    logic [2:0]  lvl;
    logic [31:0] total;
    logic        last;
  } log_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  char_in_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [13:0] ring_index_o;
  logic [7:0]  byte_written_o;
  logic [2:0]  line_level_o;
  logic [31:0] total_logged_o;
  logic        last_o;

  log_level_tagger_ring_top #(.LOG_DEPTH(LogDepth)) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .char_in_i      (char_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .ring_index_o   (ring_index_o),
    .byte_written_o (byte_written_o),
    .line_level_o   (line_level_o),
    .total_logged_o (total_logged_o),
    .last_o         (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted store state
  log_beat_t   logged_q[$];
  int          ring_head;
  int          ring_fill;
  logic [31:0] bytes_total;
  logic        line_open;
  logic [2:0]  line_lvl;
  logic [1:0]  pfx_phase;
  logic [2:0]  pfx_digit;
  logic [2:0]  dflt_lvl;
  int          step_beats;

  int  errors;
  int  chars_sent;
  int  beats_seen;
  int  cfg_writes;
  bit  snd_idle;
  bit  rcv_idle;
  int  hold_req;
  int  stall_left;

  task automatic append_byte(input logic [7:0] b);
    int pos;
    log_beat_t e;
    pos = ring_head + ring_fill;
    if (pos >= LogDepth) pos -= LogDepth;
    if (ring_fill < LogDepth) begin
      ring_fill++;
    end else begin
      ring_head++;
      if (ring_head >= LogDepth) ring_head = 0;
    end
    bytes_total++;
    e.idx   = pos[13:0];
    e.data  = b;
    e.lvl   = line_lvl;
    e.total = bytes_total;
    e.last  = 1'b0;
    logged_q.push_back(e);
    step_beats++;
  endtask

  task automatic append_default_prefix();
    line_lvl  = dflt_lvl;
    line_open = 1'b1;
    pfx_phase = PH_LT;
    append_byte(CH_LT);
    append_byte(CH_ZERO + 8'(line_lvl));
    append_byte(CH_GT);
  endtask

  task automatic tag_and_log(input logic [7:0] c);
    log_beat_t e;
    logic [2:0] d;
    step_beats = 0;
    if (line_open) begin
      append_byte(c);
    end else if (pfx_phase == PH_LT) begin
      if (c == CH_LT) begin
        pfx_phase = PH_DIG;
      end else begin
        append_default_prefix();
        append_byte(c);
      end
    end else if (pfx_phase == PH_DIG) begin
      if (c >= CH_ZERO && c <= CH_SEVEN) begin
        pfx_digit = c[2:0];
        pfx_phase = PH_GT;
      end else begin
        append_default_prefix();
        append_byte(CH_LT);
        append_byte(c);
      end
    end else begin
      d = pfx_digit;
      if (c == CH_GT) begin
        line_lvl  = d;
        line_open = 1'b1;
        pfx_phase = PH_LT;
        append_byte(CH_LT);
        append_byte(CH_ZERO + 8'(d));
        append_byte(CH_GT);
      end else begin
        append_default_prefix();
        append_byte(CH_LT);
        append_byte(CH_ZERO + 8'(d));
        append_byte(c);
      end
    end
    if (c == CH_NL) begin
      line_open = 1'b0;
      pfx_phase = PH_LT;
    end
    if (step_beats > 0) begin
      e = logged_q.pop_back();
      e.last = 1'b1;
      logged_q.push_back(e);
    end
  endtask

  // valid stays high after a beat; callers either send again or drain in the same step
  task automatic send_char(input logic [7:0] c);
    if (snd_idle && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_in_i  <= c;
    do @(posedge clk_i); while (!in_ready_o);
    tag_and_log(c);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (logged_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_default_level(input logic [2:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dflt_lvl = v;
    cfg_writes++;
  endtask

  task automatic send_random_line();
    int kind;
    int len;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      send_char(CH_LT);
      send_char(CH_ZERO + 8'($urandom_range(0, 7)));
      send_char(CH_GT);
    end else if (kind == 7) begin
      send_char(CH_LT);
      send_char(8'($urandom_range(0, 255)));
    end else if (kind == 8) begin
      send_char(CH_LT);
      send_char(CH_ZERO + 8'($urandom_range(0, 7)));
      send_char(8'($urandom_range(0, 255)));
    end
    len = $urandom_range(0, 6);
    repeat (len) send_char(8'($urandom_range(0, 255)));
    send_char(CH_NL);
  endtask

  task automatic test_prefixes();
    snd_idle = 1'b0;
    rcv_idle = 1'b0;
    send_text("<0>A\n");
    send_text("<7>\n");
    send_text("\n");
    send_text("x\n");
    send_text("<<\n");
    send_text("<8\n");
    send_text("</\n");
    send_text("<5\n");
    send_text("<3");
    send_char(8'hFF);
    send_char(8'h00);
    send_char(CH_NL);
    drain();
  endtask

  task automatic test_default_level();
    logic [2:0] lvls[3];
    lvls[0] = 3'd0;
    lvls[1] = 3'd7;
    lvls[2] = 3'($urandom_range(1, 6));
    foreach (lvls[i]) begin
      write_default_level(lvls[i]);
      send_text("q\n");
      send_text("<2x\n");
      drain();
    end
  endtask

  task automatic test_random_stream(input int target);
    int start;
    for (int ph = 0; ph < 3; ph++) begin
      write_default_level(3'($urandom_range(0, 7)));
      start = chars_sent;
      while (chars_sent - start < target) begin
        snd_idle = ($urandom_range(0, 3) != 0);
        rcv_idle = ($urandom_range(0, 3) != 0);
        send_random_line();
      end
      drain();
    end
  endtask

  task automatic test_backpressure();
    snd_idle = 1'b0;
    rcv_idle = 1'b0;
    hold_req = 80;
    repeat (4) send_random_line();
    send_text("\n<4\n");
    drain();
  endtask

  task automatic test_back_to_back();
    logic [7:0] c;
    snd_idle = 1'b0;
    rcv_idle = 1'b0;
    write_default_level(DEFAULT_LEVEL_RST);
    send_text("<2>");
    repeat (20) begin
      c = 8'($urandom_range(0, 255));
      if (c == CH_NL) c = 8'h0B;
      send_char(c);
    end
    send_text("\nz\n");
    drain();
  endtask

  initial begin
    out_ready_i = 1'b0;
    stall_left  = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (hold_req > 0) begin
        out_ready_i <= 1'b0;
        stall_left = hold_req - 1;
        hold_req   = 0;
      end else if (rcv_idle && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = $urandom_range(0, 5);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    log_beat_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      beats_seen++;
      if (logged_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR %0t: unexpected beat idx=%0d byte=%h", $realtime, ring_index_o,
                   byte_written_o);
      end else begin
        e = logged_q.pop_front();
        if (ring_index_o !== e.idx || byte_written_o !== e.data ||
            line_level_o !== e.lvl || total_logged_o !== e.total || last_o !== e.last) begin
          errors++;
          if (errors <= 10) begin
            $write("ERROR %0t: exp idx=%0d byte=%h lvl=%0d total=%0d last=%b, ",
                   $realtime, e.idx, e.data, e.lvl, e.total, e.last);
            $display("got idx=%0d byte=%h lvl=%0d total=%0d last=%b", ring_index_o,
                     byte_written_o, line_level_o, total_logged_o, last_o);
          end
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 3'd0;
    in_valid_i  = 1'b0;
    char_in_i   = 8'h00;
    errors      = 0;
    chars_sent  = 0;
    beats_seen  = 0;
    cfg_writes  = 0;
    snd_idle    = 1'b0;
    rcv_idle    = 1'b0;
    hold_req    = 0;
    ring_head   = 0;
    ring_fill   = 0;
    bytes_total = '0;
    line_open   = 1'b0;
    line_lvl    = 3'd0;
    pfx_phase   = PH_LT;
    pfx_digit   = 3'd0;
    dflt_lvl    = DEFAULT_LEVEL_RST;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_prefixes();
    test_default_level();
    test_random_stream(20);
    test_backpressure();
    test_back_to_back();

    drain();
    repeat (10) @(posedge clk_i);
    $display("Covered: %0d chars, %0d beats, %0d default level writes",
             chars_sent, beats_seen, cfg_writes);
    $display("Prefix hits and breaks in every phase, long output stall, %0d mismatches", errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> log_level_tagger_ring_top.f
hw/rtl/lltr_pkg.sv
hw/rtl/lltr_parser.sv
hw/rtl/lltr_burst.sv
hw/rtl/lltr_ring.sv
hw/rtl/log_level_tagger_ring_top.sv
test/tb.sv
